// File: hdl/smalu_pkg.sv
// smalu_pkg: widths, command and operation codes for the small matrix unit
// no dependencies; used by the channel interfaces and small_matrix_alu_core
package smalu_pkg;

    localparam int MAX_SIZE  = 4;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 2;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
    localparam int CFG_W     = 3;
    localparam int CMD_W     = 2;
    localparam int OP_W      = 3;
    // dot product of up to MAX_SIZE shifted products, with headroom
    localparam int ACC_W     = 2 * DATA_W + IDX_W;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(MAX_SIZE);
    localparam logic [CFG_W-1:0] SIZE_MIN   = CFG_W'(2);

    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB       = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE     = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL       = 3'd3;
    localparam logic [OP_W-1:0] OP_TRANSPOSE = 3'd4;

endpackage

// File: hdl/smalu_if.sv
// smalu_req_if and smalu_rsp_if: valid/ready channels of the small matrix unit
// depends on smalu_pkg for field widths
interface smalu_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [smalu_pkg::CMD_W-1:0]          cmd;
    logic [smalu_pkg::IDX_W-1:0]          row_index;
    logic [smalu_pkg::IDX_W-1:0]          col_index;
    logic signed [smalu_pkg::DATA_W-1:0]  operand_value;
    logic [smalu_pkg::OP_W-1:0]           operation;

    modport source (output valid, cmd, row_index, col_index, operand_value, operation,
                    input ready);
    modport sink   (input valid, cmd, row_index, col_index, operand_value, operation,
                    output ready);
endinterface

interface smalu_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [smalu_pkg::IDX_W-1:0]          out_row;
    logic [smalu_pkg::IDX_W-1:0]          out_col;
    logic signed [smalu_pkg::DATA_W-1:0]  out_value;
    logic                                 saturated;
    logic                                 last;

    modport source (output valid, out_row, out_col, out_value, saturated, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, saturated, last,
                    output ready);
endinterface

// File: hdl/small_matrix_alu_core.sv
// small_matrix_alu_core: top level of the square matrix unit (add, sub, scale, mul, transpose)
// depends on smalu_pkg and the channel interfaces in smalu_if.sv
//
// A load request writes one Q16.16 element of store A or B. A run request produces the n x n
// result (n from matrix_size, clamped to 2..4) row-major, one element per response, last set on
// the final one. Each store is a 16-entry memory with one registered read port, and each result
// element is issued as n reads for multiply and one read otherwise, then passes through read
// data, product, and accumulate and emit. Requests are taken only while no run is in flight;
// a finished element sits in the output register, so the next request can be taken while the
// last response still waits. Stores need no clearing pass: entries are to be read only after
// loading, which the user must ensure; the block itself does not enforce this.
module small_matrix_alu_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [smalu_pkg::CFG_W-1:0]    i_cfg_wdata,
    smalu_req_if.sink                      i_req,
    smalu_rsp_if.source                    o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state                                r_state;
    logic [smalu_pkg::CFG_W-1:0]           r_matrix_size;
    logic [smalu_pkg::OP_W-1:0]            r_op;
    logic signed [smalu_pkg::DATA_W-1:0]   r_scalar;
    logic [smalu_pkg::IDX_W-1:0]           r_nm1;
    logic [smalu_pkg::IDX_W-1:0]           r_i;
    logic [smalu_pkg::IDX_W-1:0]           r_j;
    logic [smalu_pkg::IDX_W-1:0]           r_k;

    logic                                  r_out_vld;
    logic [smalu_pkg::IDX_W-1:0]           r_out_row;
    logic [smalu_pkg::IDX_W-1:0]           r_out_col;
    logic [smalu_pkg::DATA_W-1:0]          r_out_value;
    logic                                  r_out_sat;
    logic                                  r_out_last;

    logic [smalu_pkg::DATA_W-1:0]          r_mem_a [smalu_pkg::DEPTH];
    logic [smalu_pkg::DATA_W-1:0]          r_mem_b [smalu_pkg::DEPTH];
    logic [smalu_pkg::DATA_W-1:0]          r_a_rdata;
    logic [smalu_pkg::DATA_W-1:0]          r_b_rdata;

    logic                                  r_rd_vld;
    logic                                  r_rd_first;
    logic                                  r_rd_last;
    logic                                  r_p_vld;
    logic                                  r_p_first;
    logic                                  r_p_last;
    logic signed [smalu_pkg::ACC_W-1:0]    r_term;
    logic signed [smalu_pkg::ACC_W-1:0]    r_acc;
    logic                                  r_done;

    logic                                  req_fire;
    logic                                  run_start;
    logic [smalu_pkg::ADDR_W-1:0]          a_raddr;
    logic [smalu_pkg::ADDR_W-1:0]          b_raddr;
    logic [smalu_pkg::ADDR_W-1:0]          wr_addr;
    logic [smalu_pkg::CFG_W-1:0]           size_use;
    logic [smalu_pkg::CFG_W-1:0]           size_m1;
    logic                                  k_last;
    logic                                  elem_last;
    logic                                  out_free;
    logic                                  emit;
    logic signed [smalu_pkg::DATA_W-1:0]   a_s;
    logic signed [smalu_pkg::DATA_W-1:0]   b_s;
    logic signed [smalu_pkg::DATA_W-1:0]   mop;
    logic signed [2*smalu_pkg::DATA_W-1:0] prod;
    logic signed [2*smalu_pkg::DATA_W-1:0] prod_sh;
    logic signed [smalu_pkg::ACC_W-1:0]    n_term;
    logic [smalu_pkg::ACC_W-smalu_pkg::DATA_W:0] acc_upper;
    logic                                  acc_fits;
    logic [smalu_pkg::DATA_W-1:0]          clip_value;

    // loads and runs are only taken with the pipeline empty, so reads never race writes
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign run_start   = req_fire && (i_req.cmd == smalu_pkg::CMD_RUN) &&
                         (i_req.operation <= smalu_pkg::OP_TRANSPOSE);
    assign wr_addr     = {i_req.row_index, i_req.col_index};

    always_comb begin
        if (r_matrix_size < smalu_pkg::SIZE_MIN) begin
            size_use = smalu_pkg::SIZE_MIN;
        end else if (r_matrix_size > smalu_pkg::CFG_W'(smalu_pkg::MAX_SIZE)) begin
            size_use = smalu_pkg::CFG_W'(smalu_pkg::MAX_SIZE);
        end else begin
            size_use = r_matrix_size;
        end
        size_m1 = size_use - smalu_pkg::CFG_W'(1);
    end

    assign k_last    = (r_op == smalu_pkg::OP_MUL) ? (r_k == r_nm1) : 1'b1;
    assign elem_last = (r_i == r_nm1) && (r_j == r_nm1);
    assign out_free  = !r_out_vld || o_rsp.ready;
    assign emit      = (r_state == S_DRAIN) && r_done && out_free;

    always_comb begin
        if (r_op == smalu_pkg::OP_MUL) begin
            a_raddr = {r_i, r_k};
            b_raddr = {r_k, r_j};
        end else if (r_op == smalu_pkg::OP_TRANSPOSE) begin
            a_raddr = {r_j, r_i};
            b_raddr = {r_i, r_j};
        end else begin
            a_raddr = {r_i, r_j};
            b_raddr = {r_i, r_j};
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && (i_req.cmd == smalu_pkg::CMD_LOAD_A)) begin
            r_mem_a[wr_addr] <= i_req.operand_value;
        end
        r_a_rdata <= r_mem_a[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && (i_req.cmd == smalu_pkg::CMD_LOAD_B)) begin
            r_mem_b[wr_addr] <= i_req.operand_value;
        end
        r_b_rdata <= r_mem_b[b_raddr];
    end

    // one shared multiplier for scale and the multiply dot product
    assign a_s     = signed'(r_a_rdata);
    assign b_s     = signed'(r_b_rdata);
    assign mop     = (r_op == smalu_pkg::OP_SCALE) ? r_scalar : b_s;
    assign prod    = a_s * mop;
    assign prod_sh = prod >>> smalu_pkg::FRAC_BITS;

    always_comb begin
        unique case (r_op)
            smalu_pkg::OP_ADD:       n_term = smalu_pkg::ACC_W'(a_s) + smalu_pkg::ACC_W'(b_s);
            smalu_pkg::OP_SUB:       n_term = smalu_pkg::ACC_W'(a_s) - smalu_pkg::ACC_W'(b_s);
            smalu_pkg::OP_SCALE:     n_term = smalu_pkg::ACC_W'(prod_sh);
            smalu_pkg::OP_MUL:       n_term = smalu_pkg::ACC_W'(prod_sh);
            smalu_pkg::OP_TRANSPOSE: n_term = smalu_pkg::ACC_W'(a_s);
            default:                 n_term = '0;
        endcase
    end

    // in range iff all bits from the sign bit of the 32-bit result upward agree
    assign acc_upper  = r_acc[smalu_pkg::ACC_W-1:smalu_pkg::DATA_W-1];
    assign acc_fits   = (&acc_upper) || !(|acc_upper);
    assign clip_value = acc_fits ? r_acc[smalu_pkg::DATA_W-1:0] :
                        (r_acc[smalu_pkg::ACC_W-1] ? smalu_pkg::DATA_MIN : smalu_pkg::DATA_MAX);

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_k == '0);
        r_rd_last  <= k_last;
        r_p_first  <= r_rd_first;
        r_p_last   <= r_rd_last;
        r_term     <= n_term;
        if (r_p_vld) begin
            r_acc <= r_p_first ? r_term : (r_acc + r_term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_p_vld  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_ISSUE);
            r_p_vld  <= r_rd_vld;
            if (r_p_vld && r_p_last) begin
                r_done <= 1'b1;
            end else if (emit) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_matrix_size <= smalu_pkg::SIZE_RESET;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_matrix_size <= i_cfg_wdata;
            end
            // a new element replaces the one leaving in the same cycle
            if (r_out_vld && o_rsp.ready && !emit) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (run_start) begin
                        r_op     <= i_req.operation;
                        r_scalar <= i_req.operand_value;
                        r_nm1    <= size_m1[smalu_pkg::IDX_W-1:0];
                        r_i      <= '0;
                        r_j      <= '0;
                        r_k      <= '0;
                        r_state  <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + smalu_pkg::IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (emit) begin
                        r_out_vld   <= 1'b1;
                        r_out_row   <= r_i;
                        r_out_col   <= r_j;
                        r_out_value <= clip_value;
                        r_out_sat   <= !acc_fits;
                        r_out_last  <= elem_last;
                        if (elem_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (r_j == r_nm1) begin
                                r_j <= '0;
                                r_i <= r_i + smalu_pkg::IDX_W'(1);
                            end else begin
                                r_j <= r_j + smalu_pkg::IDX_W'(1);
                            end
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.out_row   = r_out_row;
    assign o_rsp.out_col   = r_out_col;
    assign o_rsp.out_value = signed'(r_out_value);
    assign o_rsp.saturated = r_out_sat;
    assign o_rsp.last      = r_out_last;

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_DRAIN))
        else $error("element done outside drain state");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (!r_rd_vld && !r_p_vld && !r_done))
        else $error("request taken with pipeline busy");

    a_accumulate_mul_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld && !r_p_first) |-> (r_op == smalu_pkg::OP_MUL))
        else $error("multi-term accumulate outside multiply");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && elem_last) |=> ((r_state == S_IDLE) && r_out_vld && r_out_last))
        else $error("final element did not end the run");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sat) |->
            ((r_out_value == smalu_pkg::DATA_MAX) || (r_out_value == smalu_pkg::DATA_MIN)))
        else $error("saturated element not at a range limit");

endmodule
